// File: rtl/core/three_level_priority_ticket_queue_assert.svh
// Assertion macros for the ticket queue RTL.
// Included by tpq_engine, the one module that carries concurrent checks.
`ifndef THREE_LEVEL_PRIORITY_TICKET_QUEUE_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_TICKET_QUEUE_ASSERT_SVH

// same-cycle implication
`define TPQ_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tpq assertion failed");

// next-cycle implication
`define TPQ_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tpq assertion failed");

`endif

// File: rtl/core/tpq_pkg.sv
// Types and codes for the three-level priority ticket queue.
// No dependencies.
package tpq_pkg;

    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_PROMOTE = 3'd1;
    localparam logic [2:0] CMD_LIST    = 3'd2;
    localparam logic [2:0] CMD_SERVE   = 3'd3;
    localparam logic [2:0] CMD_SEARCH  = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    localparam logic [1:0] LVL_HIGH = 2'd0;
    localparam logic [1:0] LVL_MED  = 2'd1;
    localparam logic [1:0] LVL_LOW  = 2'd2;

    localparam int MAX_RESULTS = 64;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] ticket_key;
        logic [1:0]  target_level;
        logic [31:0] create_stamp;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_key;
        logic [1:0]  out_level;
        logic [31:0] out_stamp;
        logic        last_item;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_LVL,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_EMIT
    } state_t;

endpackage

// File: rtl/core/tpq_ram.sv
// Entry store: one write port, one registered read port.
// Standalone, no package use.
module tpq_ram #(
    parameter int DEPTH     = 96,
    parameter int WIDTH     = 64,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/tpq_engine.sv
// Sequencer and shared compare/shift datapath of the ticket queue.
// Uses tpq_pkg, tpq_ram and the assertion macro header.
`include "three_level_priority_ticket_queue_assert.svh"
module tpq_engine #(
    parameter int QUEUE_DEPTH = 32,
    parameter int KEY_BITS    = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tpq_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output tpq_pkg::res_t res
);
    import tpq_pkg::*;

    localparam int SKB   = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int IW    = $clog2(QUEUE_DEPTH);
    localparam int DEPTH = 3 * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = SKB + 32;
    localparam int NW    = $clog2(MAX_RESULTS + 1);

    state_t state_reg, state_next, post_reg;
    logic [2:0]     cmd_reg;
    logic [SKB-1:0] key_reg;
    logic [1:0]     tgt_reg;
    logic [31:0]    stamp_reg;
    logic [1:0]     lvl_reg;
    logic [CW-1:0]  idx_reg;
    logic [NW-1:0]  n_reg;
    logic [CW-1:0]  cnt_reg [3];
    res_t           res_reg;

    logic           we;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic [WW-1:0]  wr_data, rd_data;
    logic [SKB-1:0] rd_key;
    logic [31:0]    rd_stamp;
    logic           acc, full_low, all_empty, in_range, match, more, tgt_full, list_last;
    logic [1:0]     serve_lvl;
    logic [CW-1:0]  idx_inc;
    logic [CW+1:0]  total;

    function automatic logic [AW-1:0] addr_of(input logic [1:0] l, input logic [IW-1:0] i);
        addr_of = AW'(l) * AW'(QUEUE_DEPTH) + AW'(i);
    endfunction

    tpq_ram #(.DEPTH(DEPTH), .WIDTH(WW)) u_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key    = rd_data[WW-1:32];
    assign rd_stamp  = rd_data[31:0];
    assign acc       = in_valid && in_ready;
    assign full_low  = (cnt_reg[LVL_LOW] == CW'(QUEUE_DEPTH));
    assign all_empty = (cnt_reg[0] == '0) && (cnt_reg[1] == '0) && (cnt_reg[2] == '0);
    assign serve_lvl = (cnt_reg[0] != '0) ? LVL_HIGH :
                       (cnt_reg[1] != '0) ? LVL_MED : LVL_LOW;
    assign in_range  = (idx_reg < cnt_reg[lvl_reg]);
    assign match     = (rd_key == key_reg);
    assign idx_inc   = idx_reg + 1'b1;
    assign more      = (idx_inc < cnt_reg[lvl_reg]);
    // only high or medium can be a move target
    assign tgt_full  = (cnt_reg[{1'b0, tgt_reg[0]}] == CW'(QUEUE_DEPTH));
    assign total     = (CW+2)'(cnt_reg[0]) + (CW+2)'(cnt_reg[1]) + (CW+2)'(cnt_reg[2]);
    assign list_last = (32'(n_reg) + 32'd1 == 32'(total)) ||
                       (32'(n_reg) + 32'd1 == 32'(MAX_RESULTS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (req.cmd)
                        CMD_INSERT:  state_next = full_low ? S_EMIT : S_INS;
                        CMD_PROMOTE: state_next = S_LVL;
                        CMD_LIST:    state_next = S_LVL;
                        CMD_SEARCH:  state_next = S_LVL;
                        CMD_SERVE:   state_next = all_empty ? S_EMIT : S_RD;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_INS:   state_next = S_EMIT;
            S_LVL:
            begin
                if (in_range)
                    state_next = S_RD;
                else if (lvl_reg == LVL_LOW)
                    state_next = S_EMIT;
            end
            S_RD:    state_next = S_CMP;
            S_CMP:
            begin
                case (cmd_reg)
                    CMD_SERVE:  state_next = S_SH_RD;
                    CMD_SEARCH: state_next = match ? S_EMIT : S_LVL;
                    CMD_PROMOTE:
                    begin
                        if (!match)
                            state_next = S_LVL;
                        else if (tgt_reg[1] || tgt_full)
                            state_next = S_EMIT;
                        else
                            state_next = S_SH_RD;
                    end
                    CMD_LIST:   state_next = S_EMIT;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_SH_RD: state_next = more ? S_SH_WR : S_EMIT;
            S_SH_WR: state_next = S_SH_RD;
            S_EMIT:  state_next = res_ready ? post_reg : S_EMIT;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and memory port drive
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        res_valid = (state_reg == S_EMIT);
        we        = 1'b0;
        wr_addr   = '0;
        wr_data   = '0;
        rd_addr   = '0;
        case (state_reg)
            S_INS:
            begin
                we      = 1'b1;
                wr_addr = addr_of(LVL_LOW, cnt_reg[LVL_LOW][IW-1:0]);
                wr_data = {key_reg, stamp_reg};
            end
            S_RD:    rd_addr = addr_of(lvl_reg, idx_reg[IW-1:0]);
            S_CMP:
            begin
                if (cmd_reg == CMD_PROMOTE && match && !tgt_reg[1] && !tgt_full)
                begin
                    we      = 1'b1;
                    wr_addr = addr_of(tgt_reg, cnt_reg[tgt_reg][IW-1:0]);
                    wr_data = rd_data;
                end
            end
            S_SH_RD: rd_addr = addr_of(lvl_reg, idx_inc[IW-1:0]);
            S_SH_WR:
            begin
                we      = 1'b1;
                wr_addr = addr_of(lvl_reg, idx_reg[IW-1:0]);
                wr_data = rd_data;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '{default: '0};
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_INS:   cnt_reg[LVL_LOW] <= cnt_reg[LVL_LOW] + 1'b1;
                S_CMP:
                begin
                    if (cmd_reg == CMD_PROMOTE && match && !tgt_reg[1] && !tgt_full)
                        cnt_reg[tgt_reg] <= cnt_reg[tgt_reg] + 1'b1;
                end
                S_SH_RD:
                begin
                    if (!more)
                        cnt_reg[lvl_reg] <= cnt_reg[lvl_reg] - 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg   <= req.cmd;
                key_reg   <= req.ticket_key[SKB-1:0];
                tgt_reg   <= req.target_level;
                stamp_reg <= req.create_stamp;
                idx_reg   <= '0;
                n_reg     <= '0;
                post_reg  <= S_IDLE;
                lvl_reg   <= (req.cmd == CMD_PROMOTE) ? LVL_LOW :
                             (req.cmd == CMD_SERVE) ? serve_lvl : LVL_HIGH;
                if (req.cmd == CMD_INSERT)
                    res_reg <= '{STAT_FULL, 32'd0, LVL_LOW, 32'd0, 1'b1};
                else
                    res_reg <= '{STAT_NOT_FOUND, 32'd0, LVL_HIGH, 32'd0, 1'b1};
            end
            S_INS:   res_reg <= '{STAT_OK, 32'(key_reg), LVL_LOW, stamp_reg, 1'b1};
            S_LVL:
            begin
                if (!in_range)
                begin
                    if (lvl_reg == LVL_LOW)
                        res_reg <= '{STAT_NOT_FOUND, 32'd0, LVL_HIGH, 32'd0, 1'b1};
                    else
                    begin
                        lvl_reg <= lvl_reg + 1'b1;
                        idx_reg <= '0;
                    end
                end
            end
            S_CMP:
            begin
                case (cmd_reg)
                    CMD_SERVE:
                        res_reg <= '{STAT_OK, 32'(rd_key), lvl_reg, rd_stamp, 1'b1};
                    CMD_SEARCH:
                    begin
                        if (match)
                            res_reg <= '{STAT_OK, 32'(rd_key), lvl_reg, rd_stamp, 1'b1};
                        else
                            idx_reg <= idx_inc;
                    end
                    CMD_PROMOTE:
                    begin
                        if (!match)
                            idx_reg <= idx_inc;
                        else if (tgt_reg[1])
                            res_reg <= '{STAT_OK, 32'(rd_key), LVL_LOW, rd_stamp, 1'b1};
                        else if (tgt_full)
                            res_reg <= '{STAT_FULL, 32'd0, tgt_reg, 32'd0, 1'b1};
                        else
                            res_reg <= '{STAT_OK, 32'(rd_key), tgt_reg, rd_stamp, 1'b1};
                    end
                    CMD_LIST:
                    begin
                        res_reg  <= '{STAT_OK, 32'(rd_key), lvl_reg, rd_stamp, list_last};
                        idx_reg  <= idx_inc;
                        n_reg    <= n_reg + 1'b1;
                        post_reg <= list_last ? S_IDLE : S_LVL;
                    end
                    default: ;
                endcase
            end
            S_SH_WR: idx_reg <= idx_inc;
            default: ;
        endcase
    end

    assign res = res_reg;

    `TPQ_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(res_reg))
    `TPQ_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1,
        cnt_reg[0] <= CW'(QUEUE_DEPTH) && cnt_reg[1] <= CW'(QUEUE_DEPTH) &&
        cnt_reg[2] <= CW'(QUEUE_DEPTH))
    `TPQ_ASSERT_NEXT(a_shift_keeps_total, clk, rst_n, state_reg == S_SH_WR,
        $stable(total))
    `TPQ_ASSERT_NEXT(a_insert_path, clk, rst_n,
        acc && req.cmd == CMD_INSERT && !full_low, state_reg == S_INS)

endmodule

// File: rtl/core/three_level_priority_ticket_queue.sv
// Insert: writes the entry at the tail of low, or answers STAT_FULL when low is full. Serve:
// reads the head, then shifts each entry behind it forward. Search compares stored entries level
// by level; promote scans low and closes the gap of an entry it moves. List: a word per entry.
// One command in flight; s_tready is low until its last result word enters the output reg.
// Reset clears the three level counts at once; the entry store needs no clearing pass.
module three_level_priority_ticket_queue #(
    parameter int QUEUE_DEPTH = 32,
    parameter int KEY_BITS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // cmd[2:0], ticket_key[34:3], target_level[36:35],
                                   // create_stamp[68:37], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // status[1:0], out_key[33:2], out_level[35:34],
                                   // out_stamp[67:36], zero fill
    output logic        m_tlast    // last_item
);
    import tpq_pkg::*;

    req_t req;
    res_t res;
    logic res_valid, res_ready;
    logic out_valid_reg;
    res_t out_reg;

    assign req.cmd          = s_tdata[2:0];
    assign req.ticket_key   = s_tdata[34:3];
    assign req.target_level = s_tdata[36:35];
    assign req.create_stamp = s_tdata[68:37];

    tpq_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .KEY_BITS(KEY_BITS)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output word register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.out_stamp, out_reg.out_level, out_reg.out_key,
                       out_reg.status};
    assign m_tlast  = out_reg.last_item;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the three-level priority ticket queue.
// Depends on tpq_pkg and three_level_priority_ticket_queue; drives the slave
// stream with random gaps and checks every master-side word against a predictor.
`timescale 1ns / 1ps

module tb;
    import tpq_pkg::*;

    localparam int DEPTH     = 32;
    localparam int LEVELS    = 3;
    localparam int WDOG_MAX  = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;

    three_level_priority_ticket_queue #(.QUEUE_DEPTH(DEPTH), .KEY_BITS(32)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // predictor state
    logic [31:0] q_key   [LEVELS][DEPTH];
    logic [31:0] q_stamp [LEVELS][DEPTH];
    int          q_cnt   [LEVELS];

    req_t pending_cmds[$];
    res_t expected_words[$];

    int   errors;
    int   hold_off;        // long receiver stall requested by stimulus
    bit   stim_done;
    int   idle_cycles;
    int   keys_seen[$];    // keys inserted so far, for hits

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic res_t mk(logic [1:0] st, logic [31:0] k, logic [1:0] lv,
                                logic [31:0] s, logic l);
        res_t r;
        r.status = st; r.out_key = k; r.out_level = lv; r.out_stamp = s; r.last_item = l;
        return r;
    endfunction

    function automatic void drop_entry(int lv, int pos);
        for (int i = pos; i + 1 < q_cnt[lv]; i++)
        begin
            q_key[lv][i]   = q_key[lv][i+1];
            q_stamp[lv][i] = q_stamp[lv][i+1];
        end
        q_cnt[lv]--;
    endfunction

    function automatic int find_key(int lv, logic [31:0] k);
        for (int i = 0; i < q_cnt[lv]; i++)
            if (q_key[lv][i] == k)
                return i;
        return -1;
    endfunction

    // predicts the words one ticket command produces
    function automatic void predict_ticket_cmd(req_t r);
        int pos;
        int n;
        int tl;
        res_t w;
        case (r.cmd)
            CMD_INSERT:
                if (q_cnt[LVL_LOW] < DEPTH)
                begin
                    q_key[LVL_LOW][q_cnt[LVL_LOW]]   = r.ticket_key;
                    q_stamp[LVL_LOW][q_cnt[LVL_LOW]] = r.create_stamp;
                    q_cnt[LVL_LOW]++;
                    expected_words.push_back(mk(STAT_OK, r.ticket_key, LVL_LOW,
                                                r.create_stamp, 1'b1));
                end
                else
                    expected_words.push_back(mk(STAT_FULL, '0, LVL_LOW, '0, 1'b1));
            CMD_PROMOTE:
            begin
                pos = find_key(LVL_LOW, r.ticket_key);
                tl = r.target_level;
                if (pos < 0)
                    expected_words.push_back(mk(STAT_NOT_FOUND, '0, '0, '0, 1'b1));
                else if (tl >= LVL_LOW)
                    expected_words.push_back(mk(STAT_OK, q_key[LVL_LOW][pos], LVL_LOW,
                                                q_stamp[LVL_LOW][pos], 1'b1));
                else if (q_cnt[tl] >= DEPTH)
                    expected_words.push_back(mk(STAT_FULL, '0, r.target_level, '0, 1'b1));
                else
                begin
                    q_key[tl][q_cnt[tl]]   = q_key[LVL_LOW][pos];
                    q_stamp[tl][q_cnt[tl]] = q_stamp[LVL_LOW][pos];
                    q_cnt[tl]++;
                    expected_words.push_back(mk(STAT_OK, q_key[LVL_LOW][pos],
                                                r.target_level, q_stamp[LVL_LOW][pos], 1'b1));
                    drop_entry(LVL_LOW, pos);
                end
            end
            CMD_LIST:
            begin
                n = 0;
                for (int lv = 0; lv < LEVELS; lv++)
                    for (int i = 0; i < q_cnt[lv]; i++)
                        if (n < MAX_RESULTS)
                        begin
                            expected_words.push_back(mk(STAT_OK, q_key[lv][i], 2'(lv),
                                                        q_stamp[lv][i], 1'b0));
                            n++;
                        end
                if (n == 0)
                    expected_words.push_back(mk(STAT_NOT_FOUND, '0, '0, '0, 1'b1));
                else
                begin
                    w = expected_words.pop_back();
                    w.last_item = 1'b1;
                    expected_words.push_back(w);
                end
            end
            CMD_SERVE:
            begin
                n = 0;
                for (int lv = 0; lv < LEVELS && n == 0; lv++)
                    if (q_cnt[lv] > 0)
                    begin
                        expected_words.push_back(mk(STAT_OK, q_key[lv][0], 2'(lv),
                                                    q_stamp[lv][0], 1'b1));
                        drop_entry(lv, 0);
                        n = 1;
                    end
                if (n == 0)
                    expected_words.push_back(mk(STAT_NOT_FOUND, '0, '0, '0, 1'b1));
            end
            CMD_SEARCH:
            begin
                n = 0;
                for (int lv = 0; lv < LEVELS && n == 0; lv++)
                begin
                    pos = find_key(lv, r.ticket_key);
                    if (pos >= 0)
                    begin
                        expected_words.push_back(mk(STAT_OK, q_key[lv][pos], 2'(lv),
                                                    q_stamp[lv][pos], 1'b1));
                        n = 1;
                    end
                end
                if (n == 0)
                    expected_words.push_back(mk(STAT_NOT_FOUND, '0, '0, '0, 1'b1));
            end
            default: ;  // unknown codes give no word
        endcase
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] pick_key();
        if (keys_seen.size() > 0 && $urandom_range(0, 3) != 0)
            return keys_seen[$urandom_range(0, keys_seen.size() - 1)];
        return (($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 15)));
    endfunction

    task automatic add_cmd(logic [2:0] c, logic [31:0] k, logic [1:0] t, logic [31:0] s);
        req_t r;
        r.cmd = c; r.ticket_key = k; r.target_level = t; r.create_stamp = s;
        pending_cmds.push_back(r);
        if (c == CMD_INSERT)
            keys_seen.push_back(k);
    endtask

    // driver
    int gap_cnt;
    req_t cur_cmd;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_cnt  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_ticket_cmd(cur_cmd);
            if (!s_tvalid || s_tready)
            begin
                if (gap_cnt > 0 || pending_cmds.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                    if (gap_cnt > 0)
                        gap_cnt <= gap_cnt - 1;
                end
                else
                begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b0, cur_cmd.create_stamp, cur_cmd.target_level,
                                 cur_cmd.ticket_key, cur_cmd.cmd};
                    gap_cnt  <= gap_len();
                end
            end
        end
    end

    // monitor and receiver stalls
    int stall_cnt;
    res_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            stall_cnt <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word key", m_tdata[33:2], 32'd0);
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("status", 32'(m_tdata[1:0]), 32'(want.status));
                    if (m_tdata[33:2] !== want.out_key)
                        report_mismatch("out_key", m_tdata[33:2], want.out_key);
                    if (m_tdata[35:34] !== want.out_level)
                        report_mismatch("out_level", 32'(m_tdata[35:34]),
                                        32'(want.out_level));
                    if (m_tdata[67:36] !== want.out_stamp)
                        report_mismatch("out_stamp", m_tdata[67:36], want.out_stamp);
                    if (m_tlast !== want.last_item)
                        report_mismatch("last_item", 32'(m_tlast), 32'(want.last_item));
                end
            end
            if (hold_off > 0)
            begin
                m_tready  <= 1'b0;
                stall_cnt <= hold_off;
                hold_off  = 0;
            end
            else if (stall_cnt > 0)
            begin
                m_tready  <= 1'b0;
                stall_cnt <= stall_cnt - 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready  <= 1'b0;
                stall_cnt <= gap_len();
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [2:0] rand_cmd();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return CMD_INSERT;
        if (p < 58) return CMD_PROMOTE;
        if (p < 64) return CMD_LIST;
        if (p < 80) return CMD_SERVE;
        if (p < 96) return CMD_SEARCH;
        return 3'($urandom_range(5, 7));
    endfunction

    initial begin
        logic [2:0] c;
        clk = 1'b0;
        errors = 0;
        hold_off = 0;
        stim_done = 0;
        idle_cycles = 0;
        m_tready = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        for (int lv = 0; lv < LEVELS; lv++)
            q_cnt[lv] = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty cases, field extremes, every command and special case
        add_cmd(CMD_LIST, '0, 2'd0, '0);
        add_cmd(CMD_SERVE, '0, 2'd0, '0);
        add_cmd(CMD_SEARCH, 32'hFFFF_FFFF, 2'd0, '0);
        add_cmd(CMD_PROMOTE, 32'h1, 2'd0, '0);
        add_cmd(CMD_INSERT, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
        add_cmd(CMD_INSERT, 32'h0, 2'd0, 32'h0);
        add_cmd(CMD_INSERT, 32'hA5A5_5A5A, 2'd1, 32'h1234_5678);
        add_cmd(CMD_PROMOTE, 32'hA5A5_5A5A, 2'd2, '0);
        add_cmd(CMD_PROMOTE, 32'hA5A5_5A5A, 2'd3, 32'hFFFF_FFFF);
        add_cmd(CMD_PROMOTE, 32'hA5A5_5A5A, 2'd1, '0);
        add_cmd(CMD_PROMOTE, 32'hFFFF_FFFF, 2'd0, '0);
        add_cmd(CMD_SEARCH, 32'h0, 2'd0, '0);
        add_cmd(CMD_SEARCH, 32'hA5A5_5A5A, 2'd0, '0);
        add_cmd(CMD_LIST, '0, 2'd0, '0);
        add_cmd(3'd5, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
        add_cmd(3'd7, '0, 2'd0, '0);
        add_cmd(CMD_SERVE, '0, 2'd0, '0);
        add_cmd(CMD_SERVE, '0, 2'd0, '0);
        add_cmd(CMD_SERVE, '0, 2'd0, '0);
        add_cmd(CMD_SERVE, '0, 2'd0, '0);

        // fill low past full with receiver held off, then fill high and list past the result limit
        wait (pending_cmds.size() == 0 && !s_tvalid && expected_words.size() == 0);
        for (int i = 0; i < DEPTH + 2; i++)
            add_cmd(CMD_INSERT, 32'(i + 100), 2'd0, $urandom);
        hold_off = 400;
        for (int i = 0; i < DEPTH; i++)
            add_cmd(CMD_PROMOTE, 32'(i + 100), 2'd0, '0);
        for (int i = 0; i < DEPTH + 1; i++)
            add_cmd(CMD_INSERT, 32'(i + 200), 2'd0, $urandom);
        add_cmd(CMD_PROMOTE, 32'd200, 2'd0, '0);   // high is full
        add_cmd(CMD_PROMOTE, 32'd201, 2'd1, '0);
        add_cmd(CMD_INSERT, 32'd300, 2'd0, $urandom);
        add_cmd(CMD_LIST, '0, 2'd0, '0);           // more than the result limit
        add_cmd(CMD_SEARCH, 32'd231, 2'd0, '0);

        // sender pauses until the block has drained
        wait (pending_cmds.size() == 0 && !s_tvalid && expected_words.size() == 0);
        for (int i = 0; i < 40; i++)
            add_cmd(CMD_SERVE, '0, 2'd0, '0);
        keys_seen.delete();

        for (int i = 0; i < 60; i++)
        begin
            c = rand_cmd();
            add_cmd(c, pick_key(), 2'($urandom_range(0, 3)), $urandom);
        end
        add_cmd(CMD_LIST, '0, 2'd0, '0);

        wait (pending_cmds.size() == 0 && !s_tvalid && expected_words.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// File: three_level_priority_ticket_queue.f
+incdir+rtl/core
rtl/core/tpq_pkg.sv
rtl/core/tpq_ram.sv
rtl/core/tpq_engine.sv
rtl/core/three_level_priority_ticket_queue.sv
verif/tb.sv
